// File: hdl/comment_skipping_tokenizer_unit_macros.svh
// Assertion helpers shared by the tokenizer modules.
// Every macro samples on clk and is quiet while rst_n is low.
`ifndef COMMENT_SKIPPING_TOKENIZER_UNIT_MACROS_SVH
`define COMMENT_SKIPPING_TOKENIZER_UNIT_MACROS_SVH

// expr holds at every clock edge
`define CSK_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// cons holds in the same cycle as ante
`define CSK_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cons holds in the cycle after ante
`define CSK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/csk_pkg.sv
`timescale 1ns / 1ps

package csk_pkg;

  // default counter widths
  localparam int LINE_BITS_DEF   = 20;
  localparam int COLUMN_BITS_DEF = 16;

  // result buffer depth, power of two
  localparam int FIFO_DEPTH = 4;

  // byte codes the scanner looks for
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_VTAB       = 8'h0B;
  localparam logic [7:0] CH_FFEED      = 8'h0C;
  localparam logic [7:0] CH_CR         = 8'h0D;

  // core to buffer: which of the two result slots carry a word
  typedef struct packed {
    logic v0;
    logic v1;
  } push_t;

  function automatic logic is_word_byte(input logic [7:0] c);
    logic r;
    r = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
        (c >= 8'h30 && c <= 8'h39) || c == CH_UNDERSCORE || c == CH_DOT;
    return r;
  endfunction

  function automatic logic is_space_byte(input logic [7:0] c);
    logic r;
    r = c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE ||
        c == CH_VTAB || c == CH_FFEED || c == CH_CR;
    return r;
  endfunction

endpackage

// File: hdl/csk_core.sv
`timescale 1ns / 1ps
`include "comment_skipping_tokenizer_unit_macros.svh"

module csk_core #(
  parameter int LINE_BITS   = csk_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = csk_pkg::COLUMN_BITS_DEF,
  localparam int ENTRY_W    = 9 + LINE_BITS + COLUMN_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [7:0]         in_char,
  input  logic               in_eoi,
  output csk_pkg::push_t     push,
  // each entry: {last, column, line, char}
  output logic [ENTRY_W-1:0] e0_data,
  output logic [ENTRY_W-1:0] e1_data
);

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_LINE_CMT,
    MODE_BLOCK_CMT,
    MODE_BLOCK_STAR
  } mode_t;

  mode_t                  mode_r, mode_nxt;
  logic [7:0]             held_char_r, held_char_nxt;
  logic                   held_valid_r, held_valid_nxt;
  logic                   slash_pending_r, slash_pending_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic [COLUMN_BITS-1:0] col_r, col_nxt;

  logic       emit_slash, emit_held, emit_char;
  logic       held_last;
  logic       is_word, is_space;
  logic [7:0] e0_char;
  logic       e0_last;

  assign is_word  = csk_pkg::is_word_byte(in_char);
  assign is_space = csk_pkg::is_space_byte(in_char);

  // position counters, saturating; end word is not counted
  always_comb begin
    line_nxt = line_r;
    col_nxt  = col_r;
    if (in_valid && !in_eoi) begin
      if (in_char == csk_pkg::CH_NEWLINE) begin
        col_nxt = '0;
        if (line_r != '1) line_nxt = line_r + 1'b1;
      end else if (col_r != '1) begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  // scan next-state and up to two emitted bytes
  always_comb begin
    mode_nxt          = mode_r;
    held_char_nxt     = held_char_r;
    held_valid_nxt    = held_valid_r;
    slash_pending_nxt = slash_pending_r;
    emit_slash        = 1'b0;
    emit_held         = 1'b0;
    emit_char         = 1'b0;
    held_last         = 1'b1;
    if (in_valid && in_eoi) begin
      emit_slash        = slash_pending_r;
      emit_held         = held_valid_r;
      slash_pending_nxt = 1'b0;
      held_valid_nxt    = 1'b0;
      mode_nxt          = MODE_NORMAL;
    end else if (in_valid) begin
      unique case (mode_r)
        MODE_LINE_CMT: begin
          if (in_char == csk_pkg::CH_NEWLINE) mode_nxt = MODE_NORMAL;
        end
        MODE_BLOCK_CMT: begin
          if (in_char == csk_pkg::CH_STAR) mode_nxt = MODE_BLOCK_STAR;
        end
        MODE_BLOCK_STAR: begin
          if (in_char == csk_pkg::CH_SLASH) mode_nxt = MODE_NORMAL;
          else if (in_char != csk_pkg::CH_STAR) mode_nxt = MODE_BLOCK_CMT;
        end
        default: begin
          slash_pending_nxt = 1'b0;
          if (slash_pending_r && in_char == csk_pkg::CH_SLASH) begin
            mode_nxt = MODE_LINE_CMT;
          end else if (slash_pending_r && in_char == csk_pkg::CH_STAR) begin
            mode_nxt = MODE_BLOCK_CMT;
          end else begin
            // a lone slash goes out first; nothing is held behind it
            emit_slash = slash_pending_r;
            if (is_word) begin
              emit_held      = held_valid_r;
              held_last      = 1'b0;
              held_char_nxt  = in_char;
              held_valid_nxt = 1'b1;
            end else begin
              emit_held      = held_valid_r;
              held_valid_nxt = 1'b0;
              if (in_char == csk_pkg::CH_SLASH) slash_pending_nxt = 1'b1;
              else if (!is_space) emit_char = 1'b1;
            end
          end
        end
      endcase
    end
  end

  // pack emissions into slots in stream order
  always_comb begin
    if (emit_slash) begin
      e0_char = csk_pkg::CH_SLASH;
      e0_last = 1'b1;
    end else if (emit_held) begin
      e0_char = held_char_r;
      e0_last = held_last;
    end else begin
      e0_char = in_char;
      e0_last = 1'b1;
    end
  end

  assign push.v0 = emit_slash | emit_held | emit_char;
  assign push.v1 = emit_char & (emit_slash | emit_held);
  assign e0_data = {e0_last, col_nxt, line_nxt, e0_char};
  assign e1_data = {1'b1, col_nxt, line_nxt, in_char};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= MODE_NORMAL;
      held_valid_r    <= 1'b0;
      slash_pending_r <= 1'b0;
      line_r          <= '0;
      col_r           <= '0;
    end else begin
      mode_r          <= mode_nxt;
      held_valid_r    <= held_valid_nxt;
      slash_pending_r <= slash_pending_nxt;
      line_r          <= line_nxt;
      col_r           <= col_nxt;
    end
    held_char_r <= held_char_nxt;
  end

  `CSK_ASSERT_ALWAYS(a_hold_excl, !(held_valid_r && slash_pending_r), "held word and slash both pending")
  `CSK_ASSERT_IMP(a_slot_order, push.v1, push.v0, "second slot used without first")
  `CSK_ASSERT_NEXT(a_eoi_flush, in_valid && in_eoi, mode_r == MODE_NORMAL && !held_valid_r && !slash_pending_r, "end word left state behind")

endmodule

// File: hdl/csk_out_fifo.sv
`timescale 1ns / 1ps
`include "comment_skipping_tokenizer_unit_macros.svh"

module csk_out_fifo #(
  parameter int ENTRY_W = 45,
  localparam int DEPTH  = csk_pkg::FIFO_DEPTH,
  localparam int PTR_W  = $clog2(DEPTH),
  localparam int CNT_W  = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  csk_pkg::push_t     push,
  input  logic [ENTRY_W-1:0] e0_data,
  input  logic [ENTRY_W-1:0] e1_data,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ENTRY_W-1:0] out_data
);

  logic [ENTRY_W-1:0] buf_r [DEPTH];
  logic [PTR_W-1:0]   wr_r, wr_nxt;
  logic [PTR_W-1:0]   rd_r, rd_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               pop;
  logic [1:0]         n_push;

  assign n_push    = {1'b0, push.v0} + {1'b0, push.v1};
  assign pop       = out_valid & out_ready;
  assign out_valid = cnt_r != '0;
  assign out_data  = buf_r[rd_r];
  // room for a worst-case pair of words
  assign room      = cnt_r <= CNT_W'(DEPTH - 2);

  always_comb begin
    wr_nxt  = wr_r + PTR_W'(n_push);
    rd_nxt  = rd_r + PTR_W'(pop);
    cnt_nxt = cnt_r + CNT_W'(n_push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push.v0) buf_r[wr_r] <= e0_data;
    if (push.v1) buf_r[wr_r + PTR_W'(1)] <= e1_data;
  end

  `CSK_ASSERT_ALWAYS(a_cnt_range, cnt_r <= CNT_W'(DEPTH), "buffer count past depth")
  `CSK_ASSERT_IMP(a_push_room, push.v0, room, "push into a full buffer")

endmodule

// File: hdl/comment_skipping_tokenizer_unit.sv
`timescale 1ns / 1ps
// Comment-skipping tokenizer.
// Input stream: one source byte per word on in_tdata; a word with in_tlast
// high marks end of text, flushes any pending token and its data is ignored.
// Output stream: one token byte per word; out_tlast marks the final byte of
// a token, and out_tdata also carries the line and column counters as they
// stand after the input byte that caused the word.
// Comments (line and block) and whitespace produce nothing. A word byte is
// held back until the next byte shows whether the token goes on, and a slash
// is held back to see whether a comment opens.
// Throughput: one input word per cycle while the four-entry result buffer has
// room for two words; an input byte gives zero to two output words.
// Latency: a word enters the result buffer at the edge that accepts the
// input and shows on out_tvalid in the next cycle.
// Reset clears scan state, counters and the buffer; nothing is shown.
// When the receiver stalls, the buffer fills and in_tready drops once fewer
// than two entries are free.
module comment_skipping_tokenizer_unit #(
  parameter int LINE_BITS   = csk_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = csk_pkg::COLUMN_BITS_DEF,
  localparam int ENTRY_W    = 9 + LINE_BITS + COLUMN_BITS,
  localparam int PAY_W      = 8 + LINE_BITS + COLUMN_BITS,
  localparam int TDATA_W    = ((PAY_W + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,  // char_code
  input  logic               in_tlast,  // end_of_input
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata, // token_char, line_number, column_number
  output logic               out_tlast  // token_last
);

  csk_pkg::push_t     push;
  logic [ENTRY_W-1:0] e0_data, e1_data, head;
  logic               room;
  logic               accept;

  assign in_tready = room;
  assign accept    = in_tvalid & room;

  csk_core #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .in_char  (in_tdata),
    .in_eoi   (in_tlast),
    .push     (push),
    .e0_data  (e0_data),
    .e1_data  (e1_data)
  );

  csk_out_fifo #(
    .ENTRY_W (ENTRY_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .e0_data   (e0_data),
    .e1_data   (e1_data),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (head)
  );

  // head entry is {last, column, line, char}
  assign out_tlast = head[ENTRY_W-1];
  assign out_tdata = TDATA_W'(head[PAY_W-1:0]);

endmodule
